// ----- src/phrl_pkg.sv -----
// phrl_pkg: shared constants, opcode codes and controller/datapath structs
// for the position history ring log; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package phrl_pkg;

  localparam int CAPACITY = 256;
  // slot address, record count and age register widths
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (AW > 8) ? AW : 8;
  // one ram word: altitude, latitude, longitude, minute stamp
  localparam int RW = 72;

  typedef enum logic [1:0] {
    OP_APPEND      = 2'd0,
    OP_READ_AGE    = 2'd1,
    OP_SEARCH      = 2'd2,
    OP_READ_OLDEST = 2'd3
  } opcode_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic age_sub;
    logic rd_issue;
    logic rd_load;
    logic srch_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    age_ge_cap;
    logic    srch_hit;
    logic    srch_done;
    logic    out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- src/phrl_if.sv -----
// phrl_in_if / phrl_out_if: valid-ready channels of the ring log
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface phrl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] rec_altitude;
  logic [15:0] rec_latitude;
  logic [15:0] rec_longitude;
  logic [23:0] rec_minutes;
  logic [7:0]  age_index;

  modport source (output valid, opcode, rec_altitude, rec_latitude, rec_longitude,
                  rec_minutes, age_index, input ready);
  modport sink (input valid, opcode, rec_altitude, rec_latitude, rec_longitude,
                rec_minutes, age_index, output ready);
endinterface

interface phrl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_altitude;
  logic [15:0] out_latitude;
  logic [15:0] out_longitude;
  logic [23:0] out_minutes;
  logic [7:0]  found_index;
  logic        found_flag;
  logic [8:0]  record_count;

  modport source (output valid, out_altitude, out_latitude, out_longitude, out_minutes,
                  found_index, found_flag, record_count, input ready);
  modport sink (input valid, out_altitude, out_latitude, out_longitude, out_minutes,
                found_index, found_flag, record_count, output ready);
endinterface
`default_nettype wire

// ----- src/position_history_ring_log_unit.sv -----
// position_history_ring_log_unit: top level of the position record ring log
// depends on phrl_pkg, phrl_if, phrl_ctrl, phrl_dp (and phrl_ram below it)
//
//   channel  direction  payload
//   in_ch    sink       opcode, record fields, minute stamp or threshold, age
//   out_ch   source     record fields, found index and flag, record count
//
// one transaction at a time; an append passes capture, decode and write to the output
// register, read-by-age and read-oldest pass decode, one reduce step per CAPACITY folded
// out of the age, ram address and ram data, a search scans from the newest record and
// stops at the first hit or the fill count; one ram read port scanning a stamp a cycle
// reset clears pointers, count, output valid and search pending flag; the fill count masks unwritten slots
// the output register lets the next transaction in while a result is held
`timescale 1ns / 1ps
`default_nettype none
module position_history_ring_log_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  phrl_in_if.sink    in_ch,
  phrl_out_if.source out_ch
);

  phrl_pkg::ctrl_cmd_t  cmd;
  phrl_pkg::dp_status_t status;

  phrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  phrl_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .status (status)
  );

endmodule
`default_nettype wire

// ----- src/phrl_ram.sv -----
// phrl_ram: generic single write port, single read port ram, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module phrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/phrl_ctrl.sv -----
// phrl_ctrl: operation sequencer of the ring log
// depends on phrl_pkg
`timescale 1ns / 1ps
`default_nettype none
module phrl_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire phrl_pkg::dp_status_t status,
  output phrl_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_REDUCE,
    S_RD_ADDR,
    S_RD_DATA,
    S_SRCH,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.op)
          phrl_pkg::OP_APPEND: state_nxt = S_WRITE;
          phrl_pkg::OP_SEARCH: state_nxt = S_SRCH;
          default:             state_nxt = S_REDUCE;
        endcase
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_FINISH;
      end
      S_REDUCE: begin
        // bring a read age into range of the ring
        if (status.age_ge_cap) begin
          cmd.age_sub = 1'b1;
        end else begin
          state_nxt = S_RD_ADDR;
        end
      end
      S_RD_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd.rd_load = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_SRCH: begin
        cmd.srch_step = 1'b1;
        if (status.srch_hit || status.srch_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/phrl_dp.sv -----
// phrl_dp: ring pointers, record ram, search scan and output register
// depends on phrl_pkg, phrl_if, phrl_ram
`timescale 1ns / 1ps
`default_nettype none
module phrl_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  phrl_in_if.sink                  in_ch,
  phrl_out_if.source               out_ch,
  input  wire phrl_pkg::ctrl_cmd_t cmd,
  output phrl_pkg::dp_status_t     status
);

  localparam int AW = phrl_pkg::AW;
  localparam int CW = phrl_pkg::CW;
  localparam int IW = phrl_pkg::IW;
  localparam int RW = phrl_pkg::RW;
  localparam logic [AW-1:0] LAST_SLOT = AW'(phrl_pkg::CAPACITY - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(phrl_pkg::CAPACITY);

  // ring state
  logic [AW-1:0] wslot_r;
  logic [CW-1:0] count_r;

  // captured transaction
  phrl_pkg::opcode_t op_r;
  logic [RW-1:0]     rec_r;
  logic [IW-1:0]     age_r;

  // search scan
  logic [AW-1:0] scan_slot_r;
  logic [CW-1:0] scan_idx_r;
  logic [CW-1:0] pend_idx_r;
  logic          pend_r;
  logic          rd_ok_r;

  // result and output registers
  logic [RW-1:0] res_rec_r;
  logic [7:0]    res_idx_r;
  logic          res_flag_r;
  logic          out_valid_r;
  logic [RW-1:0] out_rec_r;
  logic [7:0]    out_idx_r;
  logic          out_flag_r;
  logic [8:0]    out_cnt_r;

  logic [RW-1:0] rd_data;
  logic [RW-1:0] rd_word;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW:0]   age_diff;
  logic [AW-1:0] age_slot;
  logic [AW-1:0] prev_slot;
  logic [IW-1:0] oldest_age;
  logic          scan_more;
  logic          hit;

  // slot of age a is write_slot - a - 1, wrapped into the ring
  always_comb begin
    age_diff = {1'b0, wslot_r} - {1'b0, age_r[AW-1:0]} - (AW+1)'(1);
    if (age_diff[AW]) begin
      age_diff = age_diff + (AW+1)'(phrl_pkg::CAPACITY);
    end
    age_slot = age_diff[AW-1:0];
  end

  assign prev_slot  = (wslot_r == '0) ? LAST_SLOT : wslot_r - AW'(1);
  assign oldest_age = (count_r == '0) ? '0 : IW'(count_r - CW'(1));
  assign scan_more  = scan_idx_r < count_r;

  assign rd_en   = cmd.rd_issue || (cmd.srch_step && scan_more);
  assign rd_addr = cmd.rd_issue ? age_slot : scan_slot_r;

  // slots at or above the fill count were never written since reset
  assign rd_word = rd_ok_r ? rd_data : '0;
  assign hit     = pend_r && (rd_word[23:0] < rec_r[23:0]);

  phrl_ram #(
    .WIDTH (RW),
    .DEPTH (phrl_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (wslot_r),
    .wdata (rec_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (cmd.write) begin
        wslot_r <= (wslot_r == LAST_SLOT) ? '0 : wslot_r + AW'(1);
        if (count_r != FULL_CNT) begin
          count_r <= count_r + CW'(1);
        end
      end
      if (cmd.capture) begin
        pend_r <= 1'b0;
      end else if (cmd.srch_step) begin
        pend_r <= scan_more;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= phrl_pkg::opcode_t'(in_ch.opcode);
      rec_r       <= {in_ch.rec_altitude, in_ch.rec_latitude, in_ch.rec_longitude,
                      in_ch.rec_minutes};
      age_r       <= (in_ch.opcode == phrl_pkg::OP_READ_OLDEST) ? oldest_age
                                                                 : IW'(in_ch.age_index);
      scan_slot_r <= prev_slot;
      scan_idx_r  <= '0;
      res_rec_r   <= '0;
      res_idx_r   <= '0;
      res_flag_r  <= 1'b0;
    end
    if (cmd.age_sub) begin
      age_r <= age_r - IW'(phrl_pkg::CAPACITY);
    end
    if (rd_en) begin
      rd_ok_r <= CW'(rd_addr) < count_r;
    end
    if (cmd.srch_step && scan_more) begin
      pend_idx_r  <= scan_idx_r;
      scan_idx_r  <= scan_idx_r + CW'(1);
      scan_slot_r <= (scan_slot_r == '0) ? LAST_SLOT : scan_slot_r - AW'(1);
    end
    if (cmd.rd_load) begin
      res_rec_r <= rd_word;
    end
    if (cmd.srch_step && hit) begin
      res_rec_r  <= rd_word;
      res_idx_r  <= 8'(pend_idx_r);
      res_flag_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_rec_r  <= res_rec_r;
      out_idx_r  <= res_idx_r;
      out_flag_r <= res_flag_r;
      out_cnt_r  <= 9'(count_r);
    end
  end

  assign status.op         = op_r;
  assign status.age_ge_cap = {1'b0, age_r} >= (IW+1)'(phrl_pkg::CAPACITY);
  assign status.srch_hit   = hit;
  assign status.srch_done  = !pend_r && !scan_more;
  assign status.out_free   = !out_valid_r || out_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_altitude  = out_rec_r[71:56];
  assign out_ch.out_latitude  = out_rec_r[55:40];
  assign out_ch.out_longitude = out_rec_r[39:24];
  assign out_ch.out_minutes   = out_rec_r[23:0];
  assign out_ch.found_index   = out_idx_r;
  assign out_ch.found_flag    = out_flag_r;
  assign out_ch.record_count  = out_cnt_r;

endmodule
`default_nettype wire

// ----- tb/phrl_log_checker.sv -----
// phrl_log_checker: watches both channels of the position ring log, predicts each
// result from its own copy of the log and compares field by field
// depends on phrl_pkg and phrl_if
`timescale 1ns / 1ps
module phrl_log_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  phrl_in_if        in_mon,
  phrl_out_if       out_mon,
  output int        fail_count,
  output int        pending,
  output int        checked
);
  import phrl_pkg::*;

  typedef struct packed {
    logic [15:0] altitude;
    logic [15:0] latitude;
    logic [15:0] longitude;
    logic [23:0] minutes;
    logic [7:0]  index;
    logic        flag;
    logic [8:0]  count;
  } log_result_t;

  log_result_t expected_results[$];

  // shadow copy of the log
  logic [47:0] pos_mem   [CAPACITY];
  logic [23:0] stamp_mem [CAPACITY];
  int unsigned wr_slot;
  int unsigned fill;

  function automatic logic [AW-1:0] slot_of(int unsigned age);
    return AW'((wr_slot + CAPACITY - (age % CAPACITY) - 1) % CAPACITY);
  endfunction

  function automatic log_result_t stored_record(logic [AW-1:0] slot);
    log_result_t r;
    r = '0;
    {r.altitude, r.latitude, r.longitude} = pos_mem[slot];
    r.minutes = stamp_mem[slot];
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    log_result_t want;
    log_result_t got;
    int unsigned a;
    if (!rst_n) begin
      wr_slot = 0;
      fill = 0;
      foreach (pos_mem[i]) begin
        pos_mem[i] = '0;
        stamp_mem[i] = '0;
      end
      expected_results.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      // a result accepted at this edge always belongs to an earlier transaction
      if (out_mon.valid && out_mon.ready) begin
        got.altitude  = out_mon.out_altitude;
        got.latitude  = out_mon.out_latitude;
        got.longitude = out_mon.out_longitude;
        got.minutes   = out_mon.out_minutes;
        got.index     = out_mon.found_index;
        got.flag      = out_mon.found_flag;
        got.count     = out_mon.record_count;
        if (expected_results.size() == 0) begin
          $error("result with no transaction pending");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          compare_field("out_altitude", 24'(want.altitude), 24'(got.altitude));
          compare_field("out_latitude", 24'(want.latitude), 24'(got.latitude));
          compare_field("out_longitude", 24'(want.longitude), 24'(got.longitude));
          compare_field("out_minutes", want.minutes, got.minutes);
          compare_field("found_index", 24'(want.index), 24'(got.index));
          compare_field("found_flag", 24'(want.flag), 24'(got.flag));
          compare_field("record_count", 24'(want.count), 24'(got.count));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = '0;
        case (opcode_t'(in_mon.opcode))
          OP_APPEND: begin
            pos_mem[AW'(wr_slot)] = {in_mon.rec_altitude, in_mon.rec_latitude,
                                     in_mon.rec_longitude};
            stamp_mem[AW'(wr_slot)] = in_mon.rec_minutes;
            wr_slot = (wr_slot + 1) % CAPACITY;
            if (fill < CAPACITY) fill++;
          end
          OP_READ_AGE: want = stored_record(slot_of(32'(in_mon.age_index)));
          OP_SEARCH: begin
            // newest first, first stamp strictly below the threshold wins
            for (a = 0; a < fill && !want.flag; a++) begin
              if (stamp_mem[slot_of(a)] < in_mon.rec_minutes) begin
                want = stored_record(slot_of(a));
                want.index = a[7:0];
                want.flag = 1'b1;
              end
            end
          end
          default: want = stored_record(slot_of((fill == 0) ? 0 : fill - 1));
        endcase
        want.count = fill[8:0];
        expected_results.push_back(want);
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ----- tb/testbench.sv -----
// testbench: drives directed and random log transactions into the position ring log,
// with random idling on both sides; the verdict comes from phrl_log_checker
// depends on phrl_pkg, phrl_if, phrl_log_checker and position_history_ring_log_unit
`timescale 1ns / 1ps
module testbench;
  import phrl_pkg::*;

  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES      = 300;
  localparam int RANDOM_ITEMS     = 430;

  logic clk;
  logic rst_n;
  logic stall_enable;
  logic long_hold;
  int fail_count;
  int pending;
  int checked;
  int op_count [4];
  int unsigned appended;
  logic [23:0] minute_clock;

  phrl_in_if  in_ch ();
  phrl_out_if out_ch ();

  position_history_ring_log_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  phrl_log_checker log_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else if (stall_enable && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("position_history_ring_log_unit: mismatch");
    $finish;
  end

  task automatic offer_item(input opcode_t op, input logic [15:0] alt,
                            input logic [15:0] lat, input logic [15:0] lon,
                            input logic [23:0] mins, input logic [7:0] age);
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.rec_altitude  <= alt;
    in_ch.rec_latitude  <= lat;
    in_ch.rec_longitude <= lon;
    in_ch.rec_minutes   <= mins;
    in_ch.age_index     <= age;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    op_count[op]++;
    if (op == OP_APPEND) appended++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_item(input int append_pct);
    opcode_t op;
    logic [15:0] alt, lat, lon;
    logic [23:0] mins;
    logic [7:0] age;
    int unsigned fill;
    fill = (appended < CAPACITY) ? appended : CAPACITY;
    alt  = 16'($urandom);
    lat  = 16'($urandom);
    lon  = 16'($urandom);
    mins = 24'($urandom);
    age  = 8'($urandom);
    if ($urandom_range(0, 99) < append_pct) begin
      op = OP_APPEND;
      // mostly a rising minute clock, now and then a stray stamp
      if ($urandom_range(0, 9) != 0) begin
        minute_clock = 24'(minute_clock + $urandom_range(1, 40));
        mins = minute_clock;
      end
    end else begin
      case ($urandom_range(0, 4))
        0, 1: begin
          op = OP_READ_AGE;
          if (fill > 0 && $urandom_range(0, 3) != 0) age = 8'($urandom_range(0, fill - 1));
        end
        2, 3: begin
          op = OP_SEARCH;
          case ($urandom_range(0, 7))
            0: mins = '0;
            1: mins = '1;
            2: ;
            default: mins = 24'(minute_clock - $urandom_range(0, 8000));
          endcase
        end
        default: op = OP_READ_OLDEST;
      endcase
    end
    offer_item(op, alt, lat, lon, mins, age);
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.opcode        <= OP_APPEND;
    in_ch.rec_altitude  <= '0;
    in_ch.rec_latitude  <= '0;
    in_ch.rec_longitude <= '0;
    in_ch.rec_minutes   <= '0;
    in_ch.age_index     <= '0;
    stall_enable = 1'b1;
    long_hold = 1'b0;
    appended = 0;
    minute_clock = 24'($urandom);
    foreach (op_count[i]) op_count[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty log: reads give zeros, search finds nothing
    offer_item(OP_READ_AGE, 16'h1234, 16'h5678, 16'h9abc, 24'h0, 8'd0);
    offer_item(OP_READ_AGE, 16'h0, 16'h0, 16'h0, 24'h0, 8'hff);
    offer_item(OP_READ_OLDEST, 16'hffff, 16'hffff, 16'hffff, 24'hffffff, 8'h0);
    offer_item(OP_SEARCH, 16'h0, 16'h0, 16'h0, 24'hffffff, 8'h0);
    // extremes and alternating patterns
    offer_item(OP_APPEND, 16'hffff, 16'hffff, 16'hffff, 24'hffffff, 8'hff);
    offer_item(OP_APPEND, 16'h0, 16'h0, 16'h0, 24'h0, 8'h0);
    offer_item(OP_APPEND, 16'haaaa, 16'h5555, 16'haaaa, 24'h555555, 8'h55);
    offer_item(OP_APPEND, 16'h5555, 16'haaaa, 16'h5555, 24'haaaaaa, 8'haa);
    offer_item(OP_READ_AGE, 16'h0, 16'h0, 16'h0, 24'h0, 8'd0);
    offer_item(OP_READ_AGE, 16'h0, 16'h0, 16'h0, 24'h0, 8'd3);
    // ages past the valid records land on slots never written
    offer_item(OP_READ_AGE, 16'h0, 16'h0, 16'h0, 24'h0, 8'd4);
    offer_item(OP_READ_AGE, 16'h0, 16'h0, 16'h0, 24'h0, 8'haa);
    offer_item(OP_READ_AGE, 16'h0, 16'h0, 16'h0, 24'h0, 8'h55);
    offer_item(OP_READ_AGE, 16'h0, 16'h0, 16'h0, 24'h0, 8'hff);
    offer_item(OP_READ_OLDEST, 16'h0, 16'h0, 16'h0, 24'h0, 8'h0);
    // searches: nothing below zero, newest hit, strict compare, deepest hit
    offer_item(OP_SEARCH, 16'h0, 16'h0, 16'h0, 24'h0, 8'h0);
    offer_item(OP_SEARCH, 16'h0, 16'h0, 16'h0, 24'hffffff, 8'h0);
    offer_item(OP_SEARCH, 16'h0, 16'h0, 16'h0, 24'haaaaaa, 8'h0);
    offer_item(OP_SEARCH, 16'h0, 16'h0, 16'h0, 24'h555555, 8'h0);
    offer_item(OP_SEARCH, 16'h0, 16'h0, 16'h0, 24'h000001, 8'h0);
    drain_results();

    // heavy on appends first so the log fills and wraps, then mostly lookups
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 120) long_hold = 1'b1;
      if (i == 260) drain_results();
      if (i == RANDOM_ITEMS - 60) stall_enable = 1'b0;
      random_item((i < 330) ? 85 : 30);
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d appends, %0d reads by age, %0d searches, %0d oldest reads",
             op_count[OP_APPEND], op_count[OP_READ_AGE], op_count[OP_SEARCH],
             op_count[OP_READ_OLDEST]);
    $display("%0d results compared, log wrapped %0d times", checked, appended / CAPACITY);
    if (fail_count == 0)
      $display("position_history_ring_log_unit: match");
    else
      $display("position_history_ring_log_unit: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
src/phrl_pkg.sv
src/phrl_if.sv
src/phrl_ram.sv
src/phrl_ctrl.sv
src/phrl_dp.sv
src/position_history_ring_log_unit.sv
tb/phrl_log_checker.sv
tb/testbench.sv
